// ----- rtl/core/iramdec_pkg.sv -----
// Shared types and constants for the internal RAM access decoder.
// Holds operation and route codes, address map bounds and the control structs.
// No dependencies.
package iramdec_pkg;

    localparam int OP_W    = 3;
    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 48;
    localparam int FWD_W   = 32;
    localparam int WORD_W  = 16;
    localparam int ROW_W   = 15;
    localparam int BASE_W  = 17;
    localparam int ROUTE_W = 2;
    localparam int CNT_W   = 2;

    localparam logic [OP_W-1:0] OP_PM_RD32 = 3'd0;
    localparam logic [OP_W-1:0] OP_PM_WR32 = 3'd1;
    localparam logic [OP_W-1:0] OP_PM_RD48 = 3'd2;
    localparam logic [OP_W-1:0] OP_PM_WR48 = 3'd3;
    localparam logic [OP_W-1:0] OP_DM_RD32 = 3'd4;
    localparam logic [OP_W-1:0] OP_DM_WR32 = 3'd5;

    localparam logic [ROUTE_W-1:0] ROUTE_INT = 2'd0;
    localparam logic [ROUTE_W-1:0] ROUTE_IO  = 2'd1;
    localparam logic [ROUTE_W-1:0] ROUTE_EXT = 2'd2;
    localparam logic [ROUTE_W-1:0] ROUTE_ERR = 2'd3;

    localparam logic [ADDR_W-1:0] NORM_LO    = 32'h0002_0000;
    localparam logic [ADDR_W-1:0] NORM_HI    = 32'h0004_0000;
    localparam logic [ADDR_W-1:0] NORM_BLK1  = 32'h0002_8000;
    localparam logic [ADDR_W-1:0] SHORT_LO   = 32'h0004_0000;
    localparam logic [ADDR_W-1:0] SHORT_HI   = 32'h0008_0000;
    localparam logic [ADDR_W-1:0] SHORT_BLK1 = 32'h0005_0000;
    localparam logic [ADDR_W-1:0] IO_HI      = 32'h0000_0100;

    localparam logic [CNT_W-1:0] WORDS_NONE  = 2'd0;
    localparam logic [CNT_W-1:0] WORDS_SHORT = 2'd1;
    localparam logic [CNT_W-1:0] WORDS_32    = 2'd2;
    localparam logic [CNT_W-1:0] WORDS_48    = 2'd3;

    typedef struct packed {
        logic load_req;
        logic load_idx;
        logic issue;
        logic load_out;
    } iramdec_cmd_t;

    typedef struct packed {
        logic no_access;
        logic last_word;
    } iramdec_status_t;

endpackage

// ----- rtl/core/dsp_internal_ram_access_decoder_top.sv -----
// Top level of the internal RAM access decoder.
// Depends on iramdec_pkg, iramdec_ctrl and iramdec_dp.
//
// Channel   Handshake             Payload
// ------    --------------------  ---------------------------------------------
// in        in_valid / in_stall   operation, address, write_data
// out       out_valid / out_stall read_data, route, forward_address,
//                                 forward_write, forward_data
// cfg       cfg_we                cfg_wdata (short_sign_extend)
//
// One request at a time: forwards and errors skip the word access states,
// while internal accesses make 1 to 3 word accesses.
// Each 16-bit word is one access on the selected RAM block's single port.
// The word index is reduced modulo the RAM depth in the S_MUL, S_QD and S_IDX states.
// Reset clears the controller, the output valid and short_sign_extend.
// A stalled result stays in the output register while the next request is taken.
module dsp_internal_ram_access_decoder_top
    import iramdec_pkg::*;
#(
    parameter int ROW_COUNT = 32768
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic [ADDR_W-1:0]   address,
    input  logic [DATA_W-1:0]   write_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DATA_W-1:0]   read_data,
    output logic [ROUTE_W-1:0]  route,
    output logic [ADDR_W-1:0]   forward_address,
    output logic                forward_write,
    output logic [FWD_W-1:0]    forward_data,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    iramdec_cmd_t    cmd;
    iramdec_status_t status;

    iramdec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    iramdec_dp #(
        .ROW_COUNT (ROW_COUNT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .operation       (operation),
        .address         (address),
        .write_data      (write_data),
        .read_data       (read_data),
        .route           (route),
        .forward_address (forward_address),
        .forward_write   (forward_write),
        .forward_data    (forward_data)
    );

endmodule

// ----- rtl/core/iramdec_ram.sv -----
// Generic single-port RAM with registered read data.
// Depends on nothing; width and depth are parameters.
module iramdec_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/iramdec_ctrl.sv -----
// Controller state machine for the internal RAM access decoder.
// Depends on iramdec_pkg; drives commands to iramdec_dp and owns the output valid.
module iramdec_ctrl
    import iramdec_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  iramdec_status_t status,
    output iramdec_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_QD   = 7'b0000100,
        S_IDX  = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_WAIT = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_QD;
            end
            S_QD:
            begin
                state_next = S_IDX;
            end
            S_IDX:
            begin
                cmd.load_idx = 1'b1;
                state_next   = status.no_access ? S_DONE : S_ACC;
            end
            S_ACC:
            begin
                cmd.issue = 1'b1;
                if (status.last_word)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/iramdec_dp.sv -----
// Datapath for the internal RAM access decoder: request registers, address
// decode, word index reduction, two RAM blocks and the result register.
// Depends on iramdec_pkg and iramdec_ram; commanded by iramdec_ctrl.
module iramdec_dp
    import iramdec_pkg::*;
#(
    parameter int ROW_COUNT = 32768
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  iramdec_cmd_t        cmd,
    output iramdec_status_t     status,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic [OP_W-1:0]     operation,
    input  logic [ADDR_W-1:0]   address,
    input  logic [DATA_W-1:0]   write_data,
    output logic [DATA_W-1:0]   read_data,
    output logic [ROUTE_W-1:0]  route,
    output logic [ADDR_W-1:0]   forward_address,
    output logic                forward_write,
    output logic [FWD_W-1:0]    forward_data
);

    localparam int DEPTH             = 3 * ROW_COUNT;
    localparam int IDX_W             = $clog2(DEPTH);
    localparam int MOD_SH            = 34;
    localparam longint unsigned RECIP = (64'd1 << MOD_SH) / DEPTH;
    localparam int RECIP_W           = $clog2(RECIP + 1);
    localparam int PROD_W            = BASE_W + RECIP_W;

    // request
    logic [OP_W-1:0]   op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic              sse_reg;

    // decode
    logic               is_write;
    logic               in_norm;
    logic               in_short;
    logic               in_io;
    logic [ROW_W-1:0]   row;
    logic [ROUTE_W-1:0] dec_route;
    logic [CNT_W-1:0]   dec_words;
    logic               dec_short;
    logic               dec_blk1;
    logic [BASE_W-1:0]  dec_base;
    logic [ADDR_W-1:0]  dec_faddr;
    logic               dec_fwr;
    logic [FWD_W-1:0]   dec_fdata;

    // index reduction
    logic [PROD_W-1:0] prod_reg;
    logic [BASE_W-1:0] qd_reg;
    logic [BASE_W-1:0] rem_raw;
    logic [BASE_W-1:0] rem_fix;

    // word access
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  remain_reg;
    logic              rd_pend_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [WORD_W-1:0] word_wdata;
    logic [WORD_W-1:0] rdata0, rdata1, rdata_sel;
    logic              en0, en1, ram_we;

    // result
    logic [DATA_W-1:0]  res_data;
    logic [DATA_W-1:0]  read_data_reg;
    logic [ROUTE_W-1:0] route_reg;
    logic [ADDR_W-1:0]  faddr_reg;
    logic               fwr_reg;
    logic [FWD_W-1:0]   fdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sse_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            sse_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg    <= operation;
            addr_reg  <= address;
            wdata_reg <= write_data;
        end
    end

    assign is_write = (op_reg == OP_PM_WR32) || (op_reg == OP_PM_WR48)
                   || (op_reg == OP_DM_WR32);
    assign in_norm  = (addr_reg >= NORM_LO) && (addr_reg < NORM_HI);
    assign in_short = (addr_reg >= SHORT_LO) && (addr_reg < SHORT_HI);
    assign in_io    = (addr_reg < IO_HI);
    assign row      = addr_reg[ROW_W-1:0];

    always_comb
    begin
        dec_route = ROUTE_ERR;
        dec_words = WORDS_NONE;
        dec_short = 1'b0;
        dec_blk1  = 1'b0;
        dec_base  = '0;
        dec_faddr = '0;
        dec_fwr   = 1'b0;
        dec_fdata = '0;
        case (op_reg)
            OP_PM_RD32, OP_PM_WR32, OP_PM_RD48, OP_PM_WR48:
            begin
                if (in_norm)
                begin
                    dec_route = ROUTE_INT;
                    dec_words = (op_reg == OP_PM_RD48 || op_reg == OP_PM_WR48)
                              ? WORDS_48 : WORDS_32;
                    dec_blk1  = (addr_reg >= NORM_BLK1);
                    dec_base  = BASE_W'({row, 1'b0}) + BASE_W'(row);
                end
            end
            OP_DM_RD32, OP_DM_WR32:
            begin
                if (in_io)
                begin
                    dec_route = ROUTE_IO;
                    dec_faddr = addr_reg;
                    dec_fwr   = is_write;
                    dec_fdata = is_write ? wdata_reg[FWD_W-1:0] : '0;
                end
                else if (in_norm)
                begin
                    dec_route = ROUTE_INT;
                    dec_words = WORDS_32;
                    dec_blk1  = (addr_reg >= NORM_BLK1);
                    dec_base  = BASE_W'({row, 1'b0});
                end
                else if (in_short)
                begin
                    dec_route = ROUTE_INT;
                    dec_words = WORDS_SHORT;
                    dec_short = 1'b1;
                    dec_blk1  = (addr_reg >= SHORT_BLK1);
                    dec_base  = BASE_W'(addr_reg[WORD_W-1:0] ^ WORD_W'(1));
                end
                else
                begin
                    dec_route = ROUTE_EXT;
                    dec_faddr = {addr_reg[ADDR_W-3:0], 2'b00};
                    dec_fwr   = is_write;
                    dec_fdata = is_write ? wdata_reg[FWD_W-1:0] : '0;
                end
            end
            default:
            begin
                dec_route = ROUTE_ERR;
            end
        endcase
    end

    // reduce base modulo DEPTH: reciprocal multiply, then one correction
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(dec_base) * PROD_W'(RECIP);
        qd_reg   <= BASE_W'((prod_reg >> MOD_SH) * PROD_W'(DEPTH));
    end

    assign rem_raw = dec_base - qd_reg;
    assign rem_fix = (rem_raw >= BASE_W'(DEPTH)) ? rem_raw - BASE_W'(DEPTH) : rem_raw;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load_idx)
        begin
            idx_next = IDX_W'(rem_fix);
        end
        else if (cmd.issue)
        begin
            idx_next = (idx_reg == IDX_W'(DEPTH - 1)) ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load_idx)
        begin
            remain_reg <= dec_words;
        end
        else if (cmd.issue)
        begin
            remain_reg <= remain_reg - CNT_W'(1);
        end
        if (cmd.load_req)
        begin
            acc_reg <= '0;
        end
        else if (rd_pend_reg)
        begin
            acc_reg <= {acc_reg[DATA_W-WORD_W-1:0], rdata_sel};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.issue && !is_write;
        end
    end

    assign status.no_access = (dec_words == WORDS_NONE);
    assign status.last_word = (remain_reg == CNT_W'(1));

    always_comb
    begin
        case (remain_reg)
            WORDS_48: word_wdata = wdata_reg[3*WORD_W-1:2*WORD_W];
            WORDS_32: word_wdata = wdata_reg[2*WORD_W-1:WORD_W];
            default:  word_wdata = wdata_reg[WORD_W-1:0];
        endcase
    end

    assign en0       = cmd.issue && !dec_blk1;
    assign en1       = cmd.issue && dec_blk1;
    assign ram_we    = is_write;
    assign rdata_sel = dec_blk1 ? rdata1 : rdata0;

    iramdec_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram0 (
        .clk   (clk),
        .en    (en0),
        .we    (ram_we),
        .addr  (idx_reg),
        .wdata (word_wdata),
        .rdata (rdata0)
    );

    iramdec_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram1 (
        .clk   (clk),
        .en    (en1),
        .we    (ram_we),
        .addr  (idx_reg),
        .wdata (word_wdata),
        .rdata (rdata1)
    );

    always_comb
    begin
        res_data = acc_reg;
        if (dec_short && sse_reg && acc_reg[WORD_W-1])
        begin
            res_data[2*WORD_W-1:WORD_W] = '1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            read_data_reg <= res_data;
            route_reg     <= dec_route;
            faddr_reg     <= dec_faddr;
            fwr_reg       <= dec_fwr;
            fdata_reg     <= dec_fdata;
        end
    end

    assign read_data       = read_data_reg;
    assign route           = route_reg;
    assign forward_address = faddr_reg;
    assign forward_write   = fwr_reg;
    assign forward_data    = fdata_reg;

endmodule

// ----- dv/iramdec_access_check.sv -----
// Checker for the internal RAM access decoder: watches the request, result and
// register ports, predicts every result and compares it field by field.
// Depends on iramdec_pkg.
`timescale 1ns / 100ps

module iramdec_access_check
    import iramdec_pkg::*;
#(
    parameter int ROW_COUNT = 32768
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic [ADDR_W-1:0]   address,
    input  logic [DATA_W-1:0]   write_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [DATA_W-1:0]   read_data,
    input  logic [ROUTE_W-1:0]  route,
    input  logic [ADDR_W-1:0]   forward_address,
    input  logic                forward_write,
    input  logic [FWD_W-1:0]    forward_data,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    output int                  mismatch_count,
    output int                  results_pending
);

    localparam int RAM_DEPTH    = 3 * ROW_COUNT;
    localparam int PM_ROW_WORDS = 3;
    localparam int DM_ROW_WORDS = 2;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [ROUTE_W-1:0] route;
        logic [ADDR_W-1:0]  forward_address;
        logic               forward_write;
        logic [FWD_W-1:0]   forward_data;
    } access_result_t;

    logic [WORD_W-1:0] ram_words [int];
    logic              sign_extend_short;
    access_result_t    expected_results [$];

    function automatic int word_key(logic blk, int unsigned idx);
        return (blk ? RAM_DEPTH : 0) + int'(idx % RAM_DEPTH);
    endfunction

    function automatic logic [WORD_W-1:0] ram_read(logic blk, int unsigned idx);
        int key;
        key = word_key(blk, idx);
        return ram_words.exists(key) ? ram_words[key] : '0;
    endfunction

    function automatic void ram_write(logic blk, int unsigned idx, logic [WORD_W-1:0] w);
        ram_words[word_key(blk, idx)] = w;
    endfunction

    function automatic access_result_t decode_access(logic [OP_W-1:0] op,
                                                     logic [ADDR_W-1:0] addr,
                                                     logic [DATA_W-1:0] wdata);
        access_result_t r;
        logic           blk;
        logic           is_wr;
        int unsigned    base;
        r = '0;
        is_wr = (op == OP_DM_WR32);
        case (op)
            OP_PM_RD32, OP_PM_WR32, OP_PM_RD48, OP_PM_WR48:
            begin
                if (addr >= NORM_LO && addr < NORM_HI)
                begin
                    blk = (addr >= NORM_BLK1);
                    base = addr[ROW_W-1:0] * PM_ROW_WORDS;
                    case (op)
                        OP_PM_RD32:
                            r.read_data = {ram_read(blk, base), ram_read(blk, base + 1)};
                        OP_PM_WR32:
                        begin
                            ram_write(blk, base, wdata[31:16]);
                            ram_write(blk, base + 1, wdata[15:0]);
                        end
                        OP_PM_RD48:
                            r.read_data = {ram_read(blk, base), ram_read(blk, base + 1),
                                           ram_read(blk, base + 2)};
                        default:
                        begin
                            ram_write(blk, base, wdata[47:32]);
                            ram_write(blk, base + 1, wdata[31:16]);
                            ram_write(blk, base + 2, wdata[15:0]);
                        end
                    endcase
                end
                else
                begin
                    r.route = ROUTE_ERR;
                end
            end
            OP_DM_RD32, OP_DM_WR32:
            begin
                if (addr < IO_HI)
                begin
                    r.route = ROUTE_IO;
                    r.forward_address = addr;
                    r.forward_write = is_wr;
                    r.forward_data = is_wr ? wdata[FWD_W-1:0] : '0;
                end
                else if (addr >= NORM_LO && addr < NORM_HI)
                begin
                    blk = (addr >= NORM_BLK1);
                    base = addr[ROW_W-1:0] * DM_ROW_WORDS;
                    if (is_wr)
                    begin
                        ram_write(blk, base, wdata[31:16]);
                        ram_write(blk, base + 1, wdata[15:0]);
                    end
                    else
                    begin
                        r.read_data = {ram_read(blk, base), ram_read(blk, base + 1)};
                    end
                end
                else if (addr >= SHORT_LO && addr < SHORT_HI)
                begin
                    blk = (addr >= SHORT_BLK1);
                    base = {addr[WORD_W-1:1], ~addr[0]};
                    if (is_wr)
                    begin
                        ram_write(blk, base, wdata[WORD_W-1:0]);
                    end
                    else
                    begin
                        r.read_data = ram_read(blk, base);
                        if (sign_extend_short && r.read_data[WORD_W-1])
                            r.read_data[31:16] = '1;
                    end
                end
                else
                begin
                    r.route = ROUTE_EXT;
                    r.forward_address = {addr[ADDR_W-3:0], 2'b00};
                    r.forward_write = is_wr;
                    r.forward_data = is_wr ? wdata[FWD_W-1:0] : '0;
                end
            end
            default:
                r.route = ROUTE_ERR;
        endcase
        return r;
    endfunction

    task automatic compare_field(string name, logic [DATA_W-1:0] exp_v,
                                 logic [DATA_W-1:0] got);
        if (got !== exp_v)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        access_result_t exp_r;
        if (!rst_n)
        begin
            sign_extend_short <= 1'b0;
            expected_results.delete();
            mismatch_count = 0;
            results_pending <= 0;
        end
        else
        begin
            if (cfg_we)
                sign_extend_short <= cfg_wdata;
            if (in_valid && !in_stall)
                expected_results.push_back(decode_access(operation, address, write_data));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending");
                    mismatch_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    compare_field("read_data", exp_r.read_data, read_data);
                    compare_field("route", exp_r.route, route);
                    compare_field("forward_address", exp_r.forward_address, forward_address);
                    compare_field("forward_write", exp_r.forward_write, forward_write);
                    compare_field("forward_data", exp_r.forward_data, forward_data);
                end
            end
            results_pending <= expected_results.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the internal RAM access decoder: clock, reset, requests,
// result stalls and register writes; the verdict comes from iramdec_access_check.
// Depends on iramdec_pkg, dsp_internal_ram_access_decoder_top and iramdec_access_check.
`timescale 1ns / 100ps

module tb;
    import iramdec_pkg::*;

    localparam int RAM_ROWS    = 16384;
    localparam int RAM_DEPTH   = 3 * RAM_ROWS;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [OP_W-1:0] OP_UNUSED_A = OP_DM_WR32 + 3'd1;
    localparam logic [OP_W-1:0] OP_UNUSED_B = OP_DM_WR32 + 3'd2;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [OP_W-1:0]    operation = OP_PM_RD32;
    logic [ADDR_W-1:0]  address = '0;
    logic [DATA_W-1:0]  write_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DATA_W-1:0]  read_data;
    logic [ROUTE_W-1:0] route;
    logic [ADDR_W-1:0]  forward_address;
    logic               forward_write;
    logic [FWD_W-1:0]   forward_data;
    logic               cfg_we = 1'b0;
    logic               cfg_wdata = 1'b0;
    int                 mismatch_count;
    int                 results_pending;
    int                 cycle_count = 0;
    int                 stall_left = 0;
    int                 burst_left = 0;
    bit                 word_written [int];

    dsp_internal_ram_access_decoder_top #(.ROW_COUNT(RAM_ROWS)) dut (.*);

    iramdec_access_check #(.ROW_COUNT(RAM_ROWS)) access_check (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
    begin : stall_gen
        int pick;
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                out_stall <= 1'b0;
                stall_left <= $urandom_range(0, 30);
            end
            else if (pick < 90)
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    function automatic logic [OP_W-1:0] write_form(logic [OP_W-1:0] op);
        case (op)
            OP_PM_RD32: return OP_PM_WR32;
            OP_PM_RD48: return OP_PM_WR48;
            OP_DM_RD32: return OP_DM_WR32;
            default:    return op;
        endcase
    endfunction

    function automatic void touched_words(input logic [OP_W-1:0] op,
                                          input logic [ADDR_W-1:0] addr,
                                          output int keys[$]);
        int unsigned base;
        int          blk_off;
        int          n;
        keys = {};
        n = 0;
        base = 0;
        blk_off = 0;
        if (op <= OP_PM_WR48 && addr >= NORM_LO && addr < NORM_HI)
        begin
            base = addr[ROW_W-1:0] * 3;
            n = (op == OP_PM_RD48 || op == OP_PM_WR48) ? 3 : 2;
            blk_off = (addr >= NORM_BLK1) ? RAM_DEPTH : 0;
        end
        else if (op == OP_DM_RD32 || op == OP_DM_WR32)
        begin
            if (addr >= NORM_LO && addr < NORM_HI)
            begin
                base = addr[ROW_W-1:0] * 2;
                n = 2;
                blk_off = (addr >= NORM_BLK1) ? RAM_DEPTH : 0;
            end
            else if (addr >= SHORT_LO && addr < SHORT_HI)
            begin
                base = {addr[WORD_W-1:1], ~addr[0]};
                n = 1;
                blk_off = (addr >= SHORT_BLK1) ? RAM_DEPTH : 0;
            end
        end
        for (int i = 0; i < n; i++)
            keys.push_back(blk_off + int'((base + i) % RAM_DEPTH));
    endfunction

    function automatic int next_gap();
        int pick;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // turn a read of never-written words into the matching write
    task automatic issue_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
        int keys[$];
        int gap;
        bit all_set;
        touched_words(op, addr, keys);
        all_set = 1'b1;
        foreach (keys[i])
            if (!word_written.exists(keys[i]))
                all_set = 1'b0;
        if (!all_set)
            op = write_form(op);
        foreach (keys[i])
            word_written[keys[i]] = 1'b1;
        gap = next_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        operation <= op;
        address <= addr;
        write_data <= data;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_config(input logic value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic issue_random_access();
        int                 pick;
        logic [OP_W-1:0]    op;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        logic [ROW_W-1:0]   row;
        logic [WORD_W-1:0]  low;
        data = {16'($urandom), 32'($urandom)};
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            op = 3'($urandom_range(OP_PM_RD32, OP_DM_WR32));
            case ($urandom_range(0, 4))
                0, 1, 2: begin row = 15'($urandom_range(0, 15)); low = 16'($urandom_range(0, 31)); end
                3:       begin row = 15'($urandom_range(16'h7ff0, 16'h7fff));
                               low = 16'($urandom_range(16'hffe0, 16'hffff)); end
                default: begin row = 15'($urandom); low = 16'($urandom); end
            endcase
            if (op <= OP_PM_WR48 || $urandom_range(0, 1))
            begin
                if ($urandom_range(0, 1))
                    addr = NORM_BLK1 + $urandom_range(0, 2) * (NORM_BLK1 - NORM_LO) + row;
                else
                    addr = NORM_LO + row;
            end
            else
            begin
                if ($urandom_range(0, 1))
                    addr = SHORT_BLK1 + $urandom_range(0, 2) * (SHORT_BLK1 - SHORT_LO) + low;
                else
                    addr = SHORT_LO + low;
            end
        end
        else if (pick < 78)
        begin
            op = $urandom_range(0, 1) ? OP_DM_WR32 : OP_DM_RD32;
            addr = $urandom_range(0, IO_HI - 1);
        end
        else if (pick < 88)
        begin
            op = $urandom_range(0, 1) ? OP_DM_WR32 : OP_DM_RD32;
            addr = $urandom_range(0, 1) ? $urandom_range(IO_HI, NORM_LO - 1)
                                        : $urandom_range(SHORT_HI, 32'hffff_ffff);
        end
        else if (pick < 96)
        begin
            op = 3'($urandom_range(OP_PM_RD32, OP_PM_WR48));
            addr = $urandom_range(0, 1) ? $urandom_range(0, NORM_LO - 1)
                                        : $urandom_range(NORM_HI, 32'hffff_ffff);
        end
        else
        begin
            op = $urandom_range(0, 1) ? OP_UNUSED_B : OP_UNUSED_A;
            addr = $urandom;
        end
        issue_access(op, addr, data);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_idle();
            issue_random_access();
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        write_config(1'b1);
        issue_access(OP_PM_WR48, NORM_LO, 48'hffff_ffff_ffff);
        issue_access(OP_PM_RD48, NORM_LO, '0);
        issue_access(OP_PM_WR32, NORM_BLK1 - 1, 48'h0000_8000_0001);
        issue_access(OP_PM_RD32, NORM_BLK1 - 1, '0);
        issue_access(OP_PM_WR48, NORM_BLK1, 48'h1234_5678_9abc);
        issue_access(OP_PM_RD48, NORM_BLK1 + 2 * (NORM_BLK1 - NORM_LO), '0);
        issue_access(OP_DM_WR32, NORM_LO + 1, 48'hffff_dead_beef);
        issue_access(OP_DM_RD32, NORM_LO + 1, '0);
        issue_access(OP_DM_WR32, SHORT_LO, 48'h0000_0000_8001);
        issue_access(OP_DM_RD32, SHORT_LO, '0);
        issue_access(OP_DM_RD32, SHORT_LO + 1, '0);
        issue_access(OP_DM_WR32, SHORT_BLK1 - 1, 48'h0000_0000_7fff);
        issue_access(OP_DM_WR32, SHORT_HI - 1, 48'hffff_ffff_ffff);
        issue_access(OP_DM_RD32, SHORT_BLK1 + 32'h0000_ffff, '0);
        issue_access(OP_DM_RD32, '0, '0);
        issue_access(OP_DM_WR32, IO_HI - 1, 48'hffff_ffff_ffff);
        issue_access(OP_DM_RD32, IO_HI, '0);
        issue_access(OP_DM_WR32, NORM_LO - 1, 48'h0000_a5a5_5a5a);
        issue_access(OP_DM_RD32, SHORT_HI, '0);
        issue_access(OP_DM_WR32, 32'hffff_ffff, 48'h5555_ffff_ffff);
        issue_access(OP_PM_RD32, NORM_LO - 1, '0);
        issue_access(OP_PM_WR48, NORM_HI, 48'hffff_ffff_ffff);
        issue_access(OP_PM_RD48, 32'hffff_ffff, '0);
        issue_access(OP_UNUSED_A, NORM_LO, 48'hffff_ffff_ffff);
        issue_access(OP_UNUSED_B, SHORT_LO, 48'hffff_ffff_ffff);
        wait_idle();

        write_config(1'b0);
        issue_access(OP_DM_RD32, SHORT_LO, '0);
        run_random(250);
        wait_idle();

        write_config(1'b1);
        run_random(250);
        wait_idle();
        repeat (20) @(negedge clk);

        if (mismatch_count == 0 && results_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
